### design/tdc_hit_stream_decoder_assert.svh
// assertion macros for the tdc hit stream decoder
`ifndef TDC_HIT_STREAM_DECODER_ASSERT_SVH
`define TDC_HIT_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TDCHSD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdchsd assertion failed");

// next-cycle implication, disabled during reset
`define TDCHSD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdchsd assertion failed");

`endif

### design/tdchsd_pkg.sv
// types, word kind codes and channel map table for the tdc hit stream decoder
package tdchsd_pkg;

	localparam logic [3:0] WK_LEAD_HIT  = 4'h4;
	localparam logic [3:0] WK_MOD_TRL   = 4'h9;
	localparam logic [3:0] WK_EVENT_TRL = 4'hB;

	localparam int unsigned CHAN_W = 14;
	localparam int unsigned TIME_W = 19;
	localparam int unsigned MODS_W = 8;
	localparam int unsigned SOCK_W = 4;

	typedef enum logic [1:0] {
		RES_HIT      = 2'd0,
		RES_EVT_OK   = 2'd1,
		RES_EVT_ERR  = 2'd2,
		RES_BAD_SOCK = 2'd3
	} result_kind_t;

	typedef struct packed {
		result_kind_t        kind;
		logic [CHAN_W-1:0]   channel;
		logic [TIME_W-1:0]   hit_time;
		logic [MODS_W-1:0]   modules_seen;
		logic [SOCK_W-1:0]   socket_code;
	} result_t;

	localparam logic [5:0] CHAN_TABLE [0:3][0:15] = '{
		'{6'h17, 6'h16, 6'h07, 6'h06, 6'h15, 6'h14, 6'h05, 6'h04,
		  6'h13, 6'h12, 6'h03, 6'h02, 6'h11, 6'h10, 6'h01, 6'h00},
		'{6'h1F, 6'h1E, 6'h0F, 6'h0E, 6'h1D, 6'h1C, 6'h0D, 6'h0C,
		  6'h1B, 6'h1A, 6'h0B, 6'h0A, 6'h19, 6'h18, 6'h09, 6'h08},
		'{6'h37, 6'h36, 6'h27, 6'h26, 6'h35, 6'h34, 6'h25, 6'h24,
		  6'h33, 6'h32, 6'h23, 6'h22, 6'h31, 6'h30, 6'h21, 6'h20},
		'{6'h3F, 6'h3E, 6'h2F, 6'h2E, 6'h3D, 6'h3C, 6'h2D, 6'h2C,
		  6'h3B, 6'h3A, 6'h2B, 6'h2A, 6'h39, 6'h38, 6'h29, 6'h28}
	};

endpackage

### design/tdchsd_decode.sv
// word decode: kind select, socket decode, channel mapping and module counter update
module tdchsd_decode #(
	parameter int unsigned MODULE_BITS = 8
) (
	input  logic [31:0]            word,
	input  logic [MODULE_BITS-1:0] count,
	input  logic [7:0]             expected,
	output logic                   has_result,
	output tdchsd_pkg::result_t    res,
	output logic [MODULE_BITS-1:0] count_next
);
	import tdchsd_pkg::*;

	localparam int unsigned CW = MODULE_BITS + 6;

	logic [3:0]                  kind;
	logic [3:0]                  sock;
	logic [1:0]                  sock_num;
	logic                        sock_ok;
	logic [5:0]                  mapped;
	logic [CW+CHAN_W-1:0]        chan_ext;
	logic [MODULE_BITS+MODS_W-1:0] mods_ext;
	logic                        count_match;

	assign kind = word[31:28];
	assign sock = word[27:24];

	always_comb begin
		sock_ok  = 1'b1;
		sock_num = 2'd0;
		unique case (sock)
			4'b0001: sock_num = 2'd0;
			4'b0010: sock_num = 2'd1;
			4'b0100: sock_num = 2'd2;
			4'b1000: sock_num = 2'd3;
			default: sock_ok = 1'b0;
		endcase
	end

	// channel bit 19 does not select the entry
	assign mapped      = CHAN_TABLE[sock_num][word[23:20]];
	assign chan_ext    = {{CHAN_W{1'b0}}, count, mapped};
	assign mods_ext    = {{MODS_W{1'b0}}, count};
	assign count_match = ({{MODS_W{1'b0}}, count} == {{MODULE_BITS{1'b0}}, expected});

	always_comb begin
		has_result       = 1'b0;
		count_next       = count;
		res.kind         = RES_HIT;
		res.channel      = '0;
		res.hit_time     = '0;
		res.modules_seen = mods_ext[MODS_W-1:0];
		res.socket_code  = '0;
		unique case (kind)
			WK_EVENT_TRL: begin
				has_result = 1'b1;
				count_next = '0;
				res.kind   = count_match ? RES_EVT_OK : RES_EVT_ERR;
			end
			WK_MOD_TRL: begin
				if (count != {MODULE_BITS{1'b1}}) begin
					count_next = count + 1'b1;
				end
			end
			WK_LEAD_HIT: begin
				has_result      = 1'b1;
				res.socket_code = sock;
				if (sock_ok) begin
					res.kind     = RES_HIT;
					res.channel  = chan_ext[CHAN_W-1:0];
					res.hit_time = word[TIME_W-1:0];
				end else begin
					res.kind = RES_BAD_SOCK;
				end
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

endmodule

### design/tdchsd_out_stage.sv
// result register driving the master stream side
module tdchsd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  tdchsd_pkg::result_t res,
	output logic                can_load,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [47:0]         m_tdata,  // hit_channel, hit_time, modules_seen, socket_code
	output logic [1:0]          m_tuser   // result_kind
);
	import tdchsd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {3'b000, res_q.socket_code, res_q.modules_seen,
	                   res_q.hit_time, res_q.channel};

endmodule

### design/tdc_hit_stream_decoder.sv
// top level of the tdc hit stream decoder
// path: input register, combinational decode, then the result register behind m_tvalid
// throughput: one word per cycle; the input register and the result register
// each take a new item in every cycle the downstream side keeps up
// reset: asynchronous, active low; clears the module counter and the valid flags,
// and sets expected_modules to 3
module tdc_hit_stream_decoder #(
	parameter int unsigned MODULE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // data_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // hit_channel, hit_time, modules_seen, socket_code
	output logic [1:0]  m_tuser,   // result_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // expected_modules
);
	import tdchsd_pkg::*;

	logic                   valid_s1;
	logic [31:0]            word_s1;
	logic [MODULE_BITS-1:0] count_q;
	logic [7:0]             expected_q;
	logic                   has_result;
	result_t                res;
	logic [MODULE_BITS-1:0] count_next;
	logic                   out_can_load;
	logic                   advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!has_result || out_can_load);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			count_q    <= '0;
			expected_q <= 8'd3;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				count_q <= count_next;
			end
			if (cfg_valid && cfg_ready) begin
				expected_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= s_tdata;
		end
	end

	tdchsd_decode #(
		.MODULE_BITS(MODULE_BITS)
	) u_decode (
		.word       (word_s1),
		.count      (count_q),
		.expected   (expected_q),
		.has_result (has_result),
		.res        (res),
		.count_next (count_next)
	);

	tdchsd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1 && has_result),
		.res      (res),
		.can_load (out_can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`include "tdc_hit_stream_decoder_assert.svh"

	`TDCHSD_ASSERT_NXT(a_count_cleared, advance && (word_s1[31:28] == WK_EVENT_TRL), count_q == '0)
	`TDCHSD_ASSERT_IMP(a_bad_sock_code, m_tvalid && (m_tuser == RES_BAD_SOCK), !$onehot(m_tdata[44:41]))
	`TDCHSD_ASSERT_IMP(a_hit_sock_code, m_tvalid && (m_tuser == RES_HIT), $onehot(m_tdata[44:41]))
	`TDCHSD_ASSERT_IMP(a_evt_no_hit, m_tvalid && ((m_tuser == RES_EVT_OK) || (m_tuser == RES_EVT_ERR)), m_tdata[32:0] == '0)

endmodule

### tb/testbench.sv
// self-checking testbench for tdc_hit_stream_decoder: random and directed word streams
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tdchsd_pkg::*;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	class decode_scoreboard;
		logic [7:0] expected_modules = 8'd3;
		logic [7:0] module_count = 8'd0;
		result_t    pending_results[$];
		int         errors = 0;

		function logic [5:0] mapped_channel(logic [1:0] socket_num, logic [3:0] idx);
			return {socket_num[1], ~idx[1], socket_num[0], ~idx[3], ~idx[2], ~idx[0]};
		endfunction

		function void set_expected(logic [7:0] value);
			expected_modules = value;
		endfunction

		function void note_word(logic [31:0] word);
			result_t    r;
			logic [3:0] sock;
			logic [1:0] num;
			bit         one_hot;
			r = '0;
			sock = word[27:24];
			case (word[31:28])
				WK_EVENT_TRL: begin
					r.kind = (module_count != expected_modules) ? RES_EVT_ERR : RES_EVT_OK;
					r.modules_seen = module_count;
					pending_results.push_back(r);
					module_count = 8'd0;
				end
				WK_MOD_TRL: begin
					if (module_count != 8'hFF)
						module_count++;
				end
				WK_LEAD_HIT: begin
					one_hot = 1'b1;
					num = 2'd0;
					case (sock)
						4'h1: num = 2'd0;
						4'h2: num = 2'd1;
						4'h4: num = 2'd2;
						4'h8: num = 2'd3;
						default: one_hot = 1'b0;
					endcase
					r.modules_seen = module_count;
					r.socket_code = sock;
					if (one_hot) begin
						r.kind = RES_HIT;
						r.channel = (14'(module_count) << 6) + 14'(mapped_channel(num, word[23:20]));
						r.hit_time = word[18:0];
					end else begin
						r.kind = RES_BAD_SOCK;
					end
					pending_results.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_result(logic [1:0] kind, logic [47:0] data);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d data %h",
					$time, kind, data);
				return;
			end
			want = pending_results.pop_front();
			compare_field("result_kind", want.kind, kind);
			compare_field("hit_channel", want.channel, data[13:0]);
			compare_field("hit_time", want.hit_time, data[32:14]);
			compare_field("modules_seen", want.modules_seen, data[40:33]);
			compare_field("socket_code", want.socket_code, data[44:41]);
			compare_field("tdata padding", 0, data[47:45]);
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function void flush_leftover();
			if (pending_results.size() != 0) begin
				$display("%0t: missing results, expected %0d more, actual 0",
					$time, pending_results.size());
				errors += pending_results.size();
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	decode_scoreboard sb = new;

	int          words_sent = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	bit          long_stall_req = 1'b0;
	int          hold_cycles = 0;
	int          rx_left = 0;
	rx_mode_t    rx_mode = RX_ALWAYS;
	logic [15:0] rx_pattern = 16'b1101_1110_0110_1011;

	tdc_hit_stream_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver stall pattern, plus long hold-off on request
	always @(posedge clk) begin
		if (long_stall_req) begin
			hold_cycles = 300;
			long_stall_req = 1'b0;
		end
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(50, 300);
		end
		rx_left--;
		rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
				default:   m_tready <= rx_pattern[0];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	function automatic logic [31:0] hit_word(logic [3:0] sock, logic [4:0] chan, logic [18:0] tm);
		return {WK_LEAD_HIT, sock, chan, tm};
	endfunction

	function automatic logic [31:0] random_hit();
		logic [3:0] sock;
		if ($urandom_range(0, 9) == 0)
			sock = 4'($urandom_range(0, 15));
		else
			sock = 4'h1 << $urandom_range(0, 3);
		return hit_word(sock, 5'($urandom_range(0, 31)), 19'($urandom_range(0, 19'h7FFFF)));
	endfunction

	function automatic logic [31:0] random_noise();
		if ($urandom_range(0, 1) == 0)
			return $urandom();
		return {4'($urandom_range(0, 3)), 28'($urandom())};
	endfunction

	task automatic send_word(input logic [31:0] word);
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		sb.note_word(word);
		words_sent++;
	endtask

	task automatic wait_results_done();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.outstanding() > 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_expected(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_expected(value);
	endtask

	task automatic run_event(input int target, input int max_mods);
		int n;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			n = target;
		else if (pick < 8)
			n = (target > 0 && pick == 6) ? target - 1 : target + 1;
		else
			n = $urandom_range(0, max_mods);
		for (int i = 0; i <= n; i++) begin
			repeat ($urandom_range(0, 2)) send_word(random_hit());
			if ($urandom_range(0, 9) == 0)
				send_word(random_noise());
			if (i < n)
				send_word({WK_MOD_TRL, 28'($urandom())});
		end
		send_word({WK_EVENT_TRL, 28'($urandom())});
	endtask

	task automatic run_phase(input logic [7:0] setting, input int target, input int words);
		int stop_at;
		write_expected(setting);
		stop_at = words_sent + words;
		while (words_sent < stop_at)
			run_event(target, 8);
		wait_results_done();
	endtask

	task automatic flood_hits();
		gaps_on = 1'b0;
		long_stall_req = 1'b1;
		repeat (80) send_word(random_hit());
		gaps_on = 1'b1;
	endtask

	initial begin
		#3_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		int stop_at;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset setting of three modules
		send_word(hit_word(4'h1, 5'd0, 19'h0));
		send_word(hit_word(4'h8, 5'h1F, 19'h7FFFF));
		send_word(hit_word(4'h0, 5'd5, 19'h123));
		send_word(hit_word(4'hF, 5'd2, 19'h4567));
		send_word(hit_word(4'h3, 5'd9, 19'h0));
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_word({4'h5, 28'hFFF_FFFF});
		send_word({WK_EVENT_TRL, 28'h0});
		repeat (3) send_word({WK_MOD_TRL, 28'hFFF_FFFF});
		send_word(hit_word(4'h2, 5'b00001, 19'h55555));
		send_word(hit_word(4'h4, 5'b11110, 19'h2AAAA));
		send_word({WK_EVENT_TRL, 28'hFFF_FFFF});
		repeat (2) send_word({WK_MOD_TRL, 28'h0});
		send_word(hit_word(4'h8, 5'd7, 19'h1));
		send_word({WK_EVENT_TRL, 28'h0});
		wait_results_done();

		stop_at = words_sent + 140;
		while (words_sent < stop_at)
			run_event(3, 8);
		wait_results_done();

		// zero expected: an event with no trailers passes
		write_expected(8'd0);
		send_word({WK_EVENT_TRL, 28'h0});
		stop_at = words_sent + 140;
		while (words_sent < stop_at)
			run_event(0, 8);
		flood_hits();
		wait_results_done();

		run_phase(8'd1, 1, 140);
		run_phase(8'd2, 2, 140);
		write_expected(8'd5);
		flood_hits();
		stop_at = words_sent + 140;
		while (words_sent < stop_at)
			run_event(5, 8);
		wait_results_done();
		run_phase(8'($urandom_range(0, 255)), $urandom_range(0, 8), 150);

		// counter saturation at the top setting
		write_expected(8'hFF);
		for (int i = 0; i < 258; i++) begin
			if (i % 16 == 0)
				send_word(random_hit());
			send_word({WK_MOD_TRL, 28'($urandom())});
		end
		send_word(hit_word(4'h8, 5'h1F, 19'h7FFFF));
		send_word(hit_word(4'h1, 5'h00, 19'h0));
		send_word({WK_EVENT_TRL, 28'($urandom())});
		repeat (100) send_word({WK_MOD_TRL, 28'($urandom())});
		send_word({WK_EVENT_TRL, 28'($urandom())});
		wait_results_done();

		run_phase(8'd3, 3, 150);
		wait_results_done();
		repeat (10) @(posedge clk);
		sb.flush_leftover();
		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule

### tdc_hit_stream_decoder.f
+incdir+design
design/tdchsd_pkg.sv
design/tdchsd_decode.sv
design/tdchsd_out_stage.sv
design/tdc_hit_stream_decoder.sv
tb/testbench.sv
